// ===== src/gedt_pkg.sv =====
// Package for the gradient edge threshold core: sizes, register indexes,
// shared result/flag types and the RGB-to-gray function.
// No dependencies.
package gedt_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 4096;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int NCOL_W = COL_W + 1;
  localparam int NROW_W = ROW_W + 1;
  localparam int PIX_W  = 8;
  localparam int THR_W  = 12;
  localparam int MAG_W  = 17;   // dx^2 + dy^2 <= 2 * 255^2

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = (NROW_W > NCOL_W) ? ((NROW_W > THR_W) ? NROW_W : THR_W)
                                                : ((NCOL_W > THR_W) ? NCOL_W : THR_W);
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  localparam int NUM_COLS_RST_I = (1024 > MAX_COLS) ? MAX_COLS : 1024;
  localparam int NUM_ROWS_RST_I = (1024 > MAX_ROWS) ? MAX_ROWS : 1024;
  localparam logic [NCOL_W-1:0] NUM_COLS_RST = NCOL_W'(NUM_COLS_RST_I);
  localparam logic [NROW_W-1:0] NUM_ROWS_RST = NROW_W'(NUM_ROWS_RST_I);
  localparam logic [NCOL_W-1:0] NUM_COLS_MAX = NCOL_W'(MAX_COLS);
  localparam logic [NROW_W-1:0] NUM_ROWS_MAX = NROW_W'(MAX_ROWS);

  // gray = floor((30r + 59g + 11b) / 100), /100 as *5243 >> 19 (exact below 43690)
  localparam int WT_RED     = 30;
  localparam int WT_GREEN   = 59;
  localparam int WT_BLUE    = 11;
  localparam int SUM_W      = 15;
  localparam int GRAY_MUL   = 5243;
  localparam int GRAY_SHIFT = 19;
  localparam int PROD_W     = 28;

  localparam logic [PIX_W-1:0] LEVEL_EDGE    = 8'd0;
  localparam logic [PIX_W-1:0] LEVEL_NO_EDGE = 8'd255;

  typedef struct packed {
    logic has_res;    // row above exists: a result for (R-1, C) is due
    logic border;     // (R-1, C) lies on the image border
    logic last_row;
    logic last_col;
  } flags_t;

  typedef struct packed {
    logic             frame_end;
    logic             run_last;
    logic [PIX_W-1:0] level;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } res_t;

  function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] r,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] b);
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
    sum  = SUM_W'(r) * SUM_W'(WT_RED) + SUM_W'(g) * SUM_W'(WT_GREEN)
         + SUM_W'(b) * SUM_W'(WT_BLUE);
    prod = PROD_W'(sum) * PROD_W'(GRAY_MUL);
    return prod[GRAY_SHIFT +: PIX_W];
  endfunction

endpackage

// ===== src/gedt_line_store.sv =====
// Two line stores of gray levels (row R-2 and row R-1) with registered read.
// Same-cycle write/read of an entry is forwarded. Depends on gedt_pkg.
module gedt_line_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [gedt_pkg::COL_W-1:0] rd_col_i,
  input  logic                       wr_en_i,
  input  logic [gedt_pkg::COL_W-1:0] wr_col_i,
  input  logic [gedt_pkg::PIX_W-1:0] wr_upper_i,
  input  logic [gedt_pkg::PIX_W-1:0] wr_mid_i,
  output logic [gedt_pkg::PIX_W-1:0] above_o,
  output logic [gedt_pkg::PIX_W-1:0] mid_o,
  output logic [gedt_pkg::PIX_W-1:0] right_o
);

  logic [gedt_pkg::PIX_W-1:0] upper_mem [gedt_pkg::MAX_COLS];
  logic [gedt_pkg::PIX_W-1:0] mid_mem   [gedt_pkg::MAX_COLS];

  logic [gedt_pkg::COL_W-1:0] rd_col_p1;
  logic [gedt_pkg::PIX_W-1:0] above_rd_q, mid_rd_q, right_rd_q;
  logic [gedt_pkg::PIX_W-1:0] fwd_upper_q, fwd_mid_q;
  logic                       fwd_c_q, fwd_r_q;

  assign rd_col_p1 = rd_col_i + gedt_pkg::COL_W'(1);

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      above_rd_q <= upper_mem[rd_col_i];
      mid_rd_q   <= mid_mem[rd_col_i];
      right_rd_q <= mid_mem[rd_col_p1];
    end
    if (wr_en_i) begin
      upper_mem[wr_col_i] <= wr_upper_i;
      mid_mem[wr_col_i]   <= wr_mid_i;
      fwd_upper_q         <= wr_upper_i;
      fwd_mid_q           <= wr_mid_i;
    end
  end

  // a read that meets a write to the same entry takes the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_c_q <= 1'b0;
      fwd_r_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_c_q <= wr_en_i && (wr_col_i == rd_col_i);
      fwd_r_q <= wr_en_i && (wr_col_i == rd_col_p1);
    end
  end

  assign above_o = fwd_c_q ? fwd_upper_q : above_rd_q;
  assign mid_o   = fwd_c_q ? fwd_mid_q   : mid_rd_q;
  assign right_o = fwd_r_q ? fwd_mid_q   : right_rd_q;

endmodule

// ===== src/gedt_out_stage.sv =====
// Output register pair: holds up to two results of one pixel and hands them
// out one per transfer. Depends on gedt_pkg.
module gedt_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              a_vld_i,
  input  gedt_pkg::res_t    a_i,
  input  logic              b_vld_i,
  input  gedt_pkg::res_t    b_i,
  input  logic              m_ready_i,
  output logic              free_o,
  output logic              m_valid_o,
  output gedt_pkg::res_t    m_res_o
);

  logic           a_vld_q, b_vld_q;
  gedt_pkg::res_t a_q, b_q;

  // free when empty, or when the only held result leaves now
  assign free_o    = (!a_vld_q && !b_vld_q) || (m_ready_i && (a_vld_q ^ b_vld_q));
  assign m_valid_o = a_vld_q || b_vld_q;
  assign m_res_o   = a_vld_q ? a_q : b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (load_i) begin
      a_vld_q <= a_vld_i;
      b_vld_q <= b_vld_i;
    end else if (m_ready_i) begin
      if (a_vld_q) begin
        a_vld_q <= 1'b0;
      end else begin
        b_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
  end

endmodule

// ===== src/gradient_edge_threshold_core.sv =====
// Gradient edge threshold core: gray conversion, line stores, gradient test.
// Depends on gedt_pkg, gedt_line_store and gedt_out_stage.
//
// Usage:
//  - s_axis carries RGB pixels in raster order (tdata: red, green, blue).
//    A pixel is taken on each transfer (tvalid & tready).
//  - m_axis carries results: tdata holds row, column and level, tlast marks
//    the last result caused by a pixel, tuser marks the frame's final result.
//  - Pixel (R, C) with R >= 1 produces the result for (R-1, C). On the last
//    row it also produces its own border result (gray level) right after.
//    The first row of a multi-row frame produces nothing.
//  - cfg_we_i/cfg_idx_i/cfg_data_i write num_cols, num_rows, threshold_q3
//    (indexes 0..2); sizes are saturated to their legal range. Write only
//    while the core is idle.
//  - A pixel passes through the line store read, gradient, squares/compare and
//    output register stages on its way to m_axis.
//  - Throughput: one pixel per clock while m_axis_tready is high; on the last
//    row two results per pixel share the single output port, which stalls s_axis there.
//  - The line stores are read with each transfer, alongside the pixel; a write-back
//    that meets a read of the same entry is forwarded, no bubble needed.
//  - Reset initialises the position counters, pipeline valids and configuration
//    registers; the line stores need no clearing pass (each entry is written before use).
//  - A stalled receiver holds the output register; pixels keep entering
//    until every stage up to it is full, then s_axis_tready drops.
module gradient_edge_threshold_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave pixel stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,   // red, green, blue
  // master result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,   // out_row, out_col, level, zero pad
  output logic                            m_axis_tlast,   // run_last
  output logic                            m_axis_tuser,   // frame_end
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [gedt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gedt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int PW = gedt_pkg::PIX_W;

  // ---------------- configuration ----------------
  logic [gedt_pkg::NCOL_W-1:0]  num_cols_q;
  logic [gedt_pkg::NROW_W-1:0]  num_rows_q;
  logic [gedt_pkg::THR_W-1:0]   thr_q;
  logic [2*gedt_pkg::THR_W-1:0] thr_sq_q;
  logic [gedt_pkg::NCOL_W-1:0]  cfg_cols;
  logic [gedt_pkg::NROW_W-1:0]  cfg_rows;

  assign cfg_cols = cfg_data_i[gedt_pkg::NCOL_W-1:0];
  assign cfg_rows = cfg_data_i[gedt_pkg::NROW_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= gedt_pkg::NUM_COLS_RST;
      num_rows_q <= gedt_pkg::NUM_ROWS_RST;
      thr_q      <= '0;
      thr_sq_q   <= '0;
    end else begin
      thr_sq_q <= (2*gedt_pkg::THR_W)'(thr_q) * (2*gedt_pkg::THR_W)'(thr_q);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gedt_pkg::REG_NUM_COLS: begin
            if (cfg_cols == '0) begin
              num_cols_q <= gedt_pkg::NCOL_W'(1);
            end else if (cfg_cols > gedt_pkg::NUM_COLS_MAX) begin
              num_cols_q <= gedt_pkg::NUM_COLS_MAX;
            end else begin
              num_cols_q <= cfg_cols;
            end
          end
          gedt_pkg::REG_NUM_ROWS: begin
            if (cfg_rows == '0) begin
              num_rows_q <= gedt_pkg::NROW_W'(1);
            end else if (cfg_rows > gedt_pkg::NUM_ROWS_MAX) begin
              num_rows_q <= gedt_pkg::NUM_ROWS_MAX;
            end else begin
              num_rows_q <= cfg_rows;
            end
          end
          gedt_pkg::REG_THRESHOLD: thr_q <= cfg_data_i[gedt_pkg::THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- stage handshake ----------------
  logic s1_vld_q, s2_vld_q, s3_vld_q;
  logic s1_move, s2_move, s3_move;
  logic s1_rdy, s2_rdy, s3_rdy;
  logic out_free;
  logic in_xfer;

  assign s3_move = s3_vld_q && out_free;
  assign s3_rdy  = !s3_vld_q || s3_move;
  assign s2_move = s2_vld_q && s3_rdy;
  assign s2_rdy  = !s2_vld_q || s2_move;
  assign s1_move = s1_vld_q && s2_rdy;
  assign s1_rdy  = !s1_vld_q || s1_move;

  assign s_axis_tready = s1_rdy;
  assign in_xfer       = s_axis_tvalid && s1_rdy;

  // ---------------- position counters ----------------
  logic [gedt_pkg::ROW_W-1:0] row_q, row_d;
  logic [gedt_pkg::COL_W-1:0] col_q, col_d;
  gedt_pkg::flags_t           in_flags;

  always_comb begin
    in_flags.last_col = ({1'b0, col_q} + gedt_pkg::NCOL_W'(1)) >= num_cols_q;
    in_flags.last_row = ({1'b0, row_q} + gedt_pkg::NROW_W'(1)) >= num_rows_q;
    in_flags.has_res  = (row_q != '0);
    // first/last column, row above is the top row, or beyond the frame
    in_flags.border   = (col_q == '0) || in_flags.last_col ||
                        (row_q == gedt_pkg::ROW_W'(1)) ||
                        ({1'b0, row_q} >= num_rows_q);
    if (in_flags.last_col) begin
      col_d = '0;
      row_d = in_flags.last_row ? '0 : row_q + gedt_pkg::ROW_W'(1);
    end else begin
      col_d = col_q + gedt_pkg::COL_W'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_xfer) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // ---------------- stage 1: line store read, gray, differences ----------------
  logic [PW-1:0]              s1_red_q, s1_green_q, s1_blue_q;
  logic [gedt_pkg::ROW_W-1:0] s1_row_q;
  logic [gedt_pkg::COL_W-1:0] s1_col_q;
  gedt_pkg::flags_t           s1_flags_q;
  logic [PW-1:0]              s1_gray, s1_above, s1_mid, s1_right;
  logic [PW-1:0]              last_mid_q;   // g(R-1, C-1): mid of previous pixel
  logic signed [PW:0]         s1_dx, s1_dy;

  gedt_line_store u_lines (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_xfer),
    .rd_col_i   (col_q),
    .wr_en_i    (s1_move),
    .wr_col_i   (s1_col_q),
    .wr_upper_i (s1_mid),
    .wr_mid_i   (s1_gray),
    .above_o    (s1_above),
    .mid_o      (s1_mid),
    .right_o    (s1_right)
  );

  assign s1_gray = gedt_pkg::gray_of(s1_red_q, s1_green_q, s1_blue_q);
  assign s1_dx   = $signed({1'b0, s1_right}) - $signed({1'b0, last_mid_q});
  assign s1_dy   = $signed({1'b0, s1_gray})  - $signed({1'b0, s1_above});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_red_q   <= s_axis_tdata[7:0];
      s1_green_q <= s_axis_tdata[15:8];
      s1_blue_q  <= s_axis_tdata[23:16];
      s1_row_q   <= row_q;
      s1_col_q   <= col_q;
      s1_flags_q <= in_flags;
    end
    if (s1_move) begin
      last_mid_q <= s1_mid;
    end
  end

  // ---------------- stage 2: squares ----------------
  logic [gedt_pkg::ROW_W-1:0] s2_row_q;
  logic [gedt_pkg::COL_W-1:0] s2_col_q;
  gedt_pkg::flags_t           s2_flags_q;
  logic [PW-1:0]              s2_gray_q, s2_mid_q;
  logic signed [PW:0]         s2_dx_q, s2_dy_q;
  logic signed [2*PW+1:0]     s2_dx_sq, s2_dy_sq;
  logic [gedt_pkg::MAG_W-1:0] s2_mag;

  assign s2_dx_sq = s2_dx_q * s2_dx_q;
  assign s2_dy_sq = s2_dy_q * s2_dy_q;
  assign s2_mag   = s2_dx_sq[gedt_pkg::MAG_W-1:0] + s2_dy_sq[gedt_pkg::MAG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_row_q   <= s1_row_q;
      s2_col_q   <= s1_col_q;
      s2_flags_q <= s1_flags_q;
      s2_gray_q  <= s1_gray;
      s2_mid_q   <= s1_mid;
      s2_dx_q    <= s1_dx;
      s2_dy_q    <= s1_dy;
    end
  end

  // ---------------- stage 3: threshold test, result build ----------------
  logic [gedt_pkg::ROW_W-1:0] s3_row_q;
  logic [gedt_pkg::COL_W-1:0] s3_col_q;
  gedt_pkg::flags_t           s3_flags_q;
  logic [PW-1:0]              s3_gray_q, s3_mid_q;
  logic [gedt_pkg::MAG_W-1:0] s3_mag_q;
  logic                       s3_edge;
  gedt_pkg::res_t             res_a, res_b;

  // 64 * mag > T^2
  assign s3_edge = (2*gedt_pkg::THR_W)'({s3_mag_q, 6'b0}) > thr_sq_q;

  always_comb begin
    res_a.row       = s3_row_q - gedt_pkg::ROW_W'(1);
    res_a.col       = s3_col_q;
    res_a.level     = s3_flags_q.border ? s3_mid_q :
                      (s3_edge ? gedt_pkg::LEVEL_EDGE : gedt_pkg::LEVEL_NO_EDGE);
    res_a.run_last  = !s3_flags_q.last_row;
    res_a.frame_end = 1'b0;
    res_b.row       = s3_row_q;
    res_b.col       = s3_col_q;
    res_b.level     = s3_gray_q;
    res_b.run_last  = 1'b1;
    res_b.frame_end = s3_flags_q.last_col;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (s3_rdy) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      s3_row_q   <= s2_row_q;
      s3_col_q   <= s2_col_q;
      s3_flags_q <= s2_flags_q;
      s3_gray_q  <= s2_gray_q;
      s3_mid_q   <= s2_mid_q;
      s3_mag_q   <= s2_mag;
    end
  end

  // ---------------- output register ----------------
  gedt_pkg::res_t m_res;

  gedt_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (s3_move),
    .a_vld_i   (s3_flags_q.has_res),
    .a_i       (res_a),
    .b_vld_i   (s3_flags_q.last_row),
    .b_i       (res_b),
    .m_ready_i (m_axis_tready),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid),
    .m_res_o   (m_res)
  );

  assign m_axis_tdata = {2'b00, m_res.level, m_res.col, m_res.row};
  assign m_axis_tlast = m_res.run_last;
  assign m_axis_tuser = m_res.frame_end;

endmodule

// ===== src/gedt_checker.sv =====
// Port-level checks for gradient_edge_threshold_core and their bind.
// Depends on gradient_edge_threshold_core's port list only.
module gedt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // no result offered in the cycle after a reset edge
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result offered during reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
                                        $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // the frame's final result closes its pixel's run
  a_frame_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame end without run end");

  // a run never breaks: its second result is ready right after the first
  a_run_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a two-result run");

endmodule

bind gradient_edge_threshold_core gedt_checker u_gedt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
